>>> rtl/core/cpds_pkg.sv
// Shared types, constants and the microcode table for the charlieplex percent
// display sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpds_pkg;

   typedef struct packed {
      logic [1:0] display_index;
      logic [7:0] level;
      logic       charging;
   } req_type;

   typedef struct packed {
      logic [1:0] module_out;
      logic [2:0] drive_high;
      logic [2:0] drive_low;
      logic       all_off;
      logic       last;
   } rsp_type;

   // Per-request digit info: lit segments a..g in bits 0..6.
   typedef struct packed {
      logic       hund;
      logic [6:0] tens_seg;
      logic [6:0] ones_seg;
   } digit_info_type;

   localparam logic [7:0] BLANK_LEVEL = 8'hFF;
   localparam logic [7:0] HUNDRED     = 8'd100;
   localparam logic [7:0] TWO_HUNDRED = 8'd200;
   localparam logic [7:0] MAX_ONE_DIG = 8'd9;
   // x/10 == (x*205)>>11 for x below 1029
   localparam logic [7:0] TENS_RECIP  = 8'd205;

   localparam int unsigned STEPS  = 19;
   localparam int unsigned STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] END_STEP = STEP_W'(STEPS - 1);

   typedef enum logic {
      OP_EMIT,
      OP_END
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_CHARGING,
      COND_HUNDREDS,
      COND_TENS,
      COND_ONES
   } cond_type;

   typedef struct packed {
      op_type     op;
      cond_type   cond;
      logic [2:0] seg_idx;
      logic [2:0] hi;
      logic [2:0] lo;
   } ctrl_word_type;

   function automatic logic [6:0] digit_segments(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

   // Microcode: one word per step. A step whose condition fails is skipped.
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         5'd0:  w = '{OP_EMIT, COND_ALWAYS,   3'd0, 3'd2, 3'd5};
         5'd1:  w = '{OP_EMIT, COND_CHARGING, 3'd0, 3'd3, 3'd5};
         5'd2:  w = '{OP_EMIT, COND_HUNDREDS, 3'd0, 3'd3, 3'd4};
         5'd3:  w = '{OP_EMIT, COND_HUNDREDS, 3'd0, 3'd2, 3'd4};
         // tens digit, line map 0
         5'd4:  w = '{OP_EMIT, COND_TENS,     3'd0, 3'd2, 3'd3};
         5'd5:  w = '{OP_EMIT, COND_TENS,     3'd1, 3'd3, 3'd2};
         5'd6:  w = '{OP_EMIT, COND_TENS,     3'd2, 3'd4, 3'd3};
         5'd7:  w = '{OP_EMIT, COND_TENS,     3'd3, 3'd4, 3'd2};
         5'd8:  w = '{OP_EMIT, COND_TENS,     3'd4, 3'd5, 3'd2};
         5'd9:  w = '{OP_EMIT, COND_TENS,     3'd5, 3'd5, 3'd3};
         5'd10: w = '{OP_EMIT, COND_TENS,     3'd6, 3'd5, 3'd4};
         // ones digit, line map 1
         5'd11: w = '{OP_EMIT, COND_ONES,     3'd0, 3'd1, 3'd2};
         5'd12: w = '{OP_EMIT, COND_ONES,     3'd1, 3'd2, 3'd1};
         5'd13: w = '{OP_EMIT, COND_ONES,     3'd2, 3'd1, 3'd3};
         5'd14: w = '{OP_EMIT, COND_ONES,     3'd3, 3'd3, 3'd1};
         5'd15: w = '{OP_EMIT, COND_ONES,     3'd4, 3'd1, 3'd4};
         5'd16: w = '{OP_EMIT, COND_ONES,     3'd5, 3'd4, 3'd1};
         5'd17: w = '{OP_EMIT, COND_ONES,     3'd6, 3'd5, 3'd1};
         default: w = '{OP_END, COND_ALWAYS,  3'd0, 3'd0, 3'd0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/charlieplex_percent_display_sequencer_unit.sv
// Charlieplex percent display sequencer: microcoded strobe generator.
// Depends on cpds_pkg and cpds_digit_split.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data) carries the display
//    index, the level and the charging flag. A request is taken only while
//    no earlier request is being sequenced.
//  - Response channel (rsp_valid/rsp_ready/rsp_data) returns the strobes in
//    order, one per accepted transfer, ending with an all-off strobe that
//    has last set. Level 255 gives only that all-off strobe.
//  - Sequencing: a 19-step microprogram runs once per request, one step per
//    cycle while the receiver does not stall an emitting step; steps whose
//    condition fails emit nothing. A blank level runs only the final step.
//    A new request is taken only after the final step has run. The first
//    strobe is loaded into the output register after the step counter, and
//    its load waits while an earlier final strobe is still held there.
//  - A stalled receiver holds the output register and freezes the step
//    counter on emitting steps; the next request can be accepted while the
//    final strobe still waits in the output register.
//  - Reset clears the sequencer and the output valid; req_ready is not gated
//    by reset, so a request offered while reset is high is dropped.
`timescale 1ns / 1ps
`default_nettype none

module charlieplex_percent_display_sequencer_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire cpds_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output cpds_pkg::rsp_type       rsp_data
);
   import cpds_pkg::*;

   logic                busy_ff;
   logic [STEP_W-1:0]   pc_ff;
   logic [1:0]          module_ff;
   logic                charging_ff;
   digit_info_type      digits_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   digit_info_type      digits_in;
   ctrl_word_type       cw;
   logic                cond_true;
   logic                out_free;
   logic                step_en;
   logic                emit;
   logic                req_fire;

   cpds_digit_split u_split (
      .level (req_data.level),
      .info  (digits_in)
   );

   assign cw = ucode(pc_ff);

   always_comb begin
      case (cw.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_CHARGING: cond_true = charging_ff;
         COND_HUNDREDS: cond_true = digits_ff.hund;
         COND_TENS:     cond_true = digits_ff.tens_seg[cw.seg_idx];
         COND_ONES:     cond_true = digits_ff.ones_seg[cw.seg_idx];
         default:       cond_true = 1'b0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = busy_ff && (!cond_true || out_free);
   assign emit      = step_en && cond_true;
   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            busy_ff <= 1'b1;
            // blank level jumps straight to the all-off step
            pc_ff   <= (req_data.level == BLANK_LEVEL) ? END_STEP : '0;
         end else if (step_en) begin
            if (cw.op == OP_END) begin
               busy_ff <= 1'b0;
            end else begin
               pc_ff <= pc_ff + 1'b1;
            end
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         module_ff   <= req_data.display_index;
         charging_ff <= req_data.charging;
         digits_ff   <= digits_in;
      end
      if (emit) begin
         rsp_data_ff.module_out <= module_ff;
         rsp_data_ff.drive_high <= cw.hi;
         rsp_data_ff.drive_low  <= cw.lo;
         rsp_data_ff.all_off    <= (cw.op == OP_END);
         rsp_data_ff.last       <= (cw.op == OP_END);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // all-off strobe is the terminating one and drives no line
   a_off_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.all_off |->
         rsp_data_ff.last && rsp_data_ff.drive_high == 3'd0 &&
         rsp_data_ff.drive_low == 3'd0)
      else $error("all-off strobe malformed");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff && !req_ready)
      else $error("sequencer not busy after request");

   a_done_emits_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff && rsp_data_ff.last)
      else $error("sequencer finished without final strobe");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= END_STEP)
      else $error("step counter out of range");

endmodule

`default_nettype wire

>>> rtl/core/cpds_digit_split.sv
// Splits a percent level into hundreds flag and tens/ones segment patterns.
// Depends on cpds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpds_digit_split (
   input  wire logic [7:0]              level,
   output cpds_pkg::digit_info_type     info
);
   import cpds_pkg::*;

   logic [6:0]  rem;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [6:0]  ones_wide;

   always_comb begin
      if (level >= TWO_HUNDRED) begin
         rem = 7'(level - TWO_HUNDRED);
      end else if (level >= HUNDRED) begin
         rem = 7'(level - HUNDRED);
      end else begin
         rem = level[6:0];
      end
   end

   assign prod      = 15'(rem) * 15'(TENS_RECIP);
   assign tens      = prod[14:11];
   assign tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
   assign ones_wide = rem - tens_x10;

   assign info.hund     = (level >= HUNDRED);
   assign info.tens_seg = (level > MAX_ONE_DIG) ? digit_segments(tens) : 7'h00;
   assign info.ones_seg = digit_segments(ones_wide[3:0]);

endmodule

`default_nettype wire

>>> tb/tb_charlieplex_percent_display_sequencer_unit.sv
// Testbench for charlieplex_percent_display_sequencer_unit: clocked request driver and
// strobe monitor, with a local predictor of the strobe sequence for each request.
// Depends on cpds_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps

module tb_charlieplex_percent_display_sequencer_unit;

   import cpds_pkg::req_type;
   import cpds_pkg::rsp_type;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 50;
   localparam int CALM_TAIL    = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 50;
   localparam int RANDOM_REQS  = 190;

   localparam logic [7:0] BLANK_CODE = 8'hFF;

   // fixed marks: high line, low line
   localparam logic [2:0] PCT_HI = 3'd2, PCT_LO = 3'd5;
   localparam logic [2:0] CHG_HI = 3'd3, CHG_LO = 3'd5;
   localparam logic [2:0] HUN1_HI = 3'd3, HUN1_LO = 3'd4;
   localparam logic [2:0] HUN2_HI = 3'd2, HUN2_LO = 3'd4;

   // lit segments per digit, digit d at [7*d +: 7], bit i = segment a..g
   localparam logic [69:0] DIGIT_LIT = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                        7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
   // segment line maps, segment i at [3*i +: 3], listed g..a
   localparam logic [20:0] TENS_HI = {3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2};
   localparam logic [20:0] TENS_LO = {3'd4, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3};
   localparam logic [20:0] ONES_HI = {3'd5, 3'd4, 3'd1, 3'd3, 3'd1, 3'd2, 3'd1};
   localparam logic [20:0] ONES_LO = {3'd1, 3'd1, 3'd4, 3'd1, 3'd3, 3'd1, 3'd2};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_strobes[$];
   rsp_type want;

   int total_reqs   = 0;
   int accept_count = 0;
   int sent_count   = 0;
   int strobe_count = 0;
   int error_count  = 0;
   int blank_reqs   = 0;
   int charge_reqs  = 0;
   int hundred_reqs = 0;
   int req_gap_left = 0;
   int rsp_stall_left = 0;
   int rsp_hold_left  = 0;
   bit rsp_hold_done  = 1'b0;
   bit calm;

   charlieplex_percent_display_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   assign calm = (accept_count + CALM_TAIL >= total_reqs);

   function automatic rsp_type make_strobe(logic [1:0] idx, logic [2:0] hi, logic [2:0] lo,
                                           logic off, logic fin);
      rsp_type s;
      s.module_out = idx;
      s.drive_high = hi;
      s.drive_low  = lo;
      s.all_off    = off;
      s.last       = fin;
      return s;
   endfunction

   // Expected strobe list for one request, appended in order.
   task automatic queue_strobes_for(req_type r);
      int         lvl;
      int         digit;
      logic [6:0] lit;
      lvl = r.level;
      if (r.level != BLANK_CODE) begin
         expected_strobes.push_back(make_strobe(r.display_index, PCT_HI, PCT_LO, 1'b0, 1'b0));
         if (r.charging)
            expected_strobes.push_back(make_strobe(r.display_index, CHG_HI, CHG_LO, 1'b0, 1'b0));
         if (lvl >= 100) begin
            expected_strobes.push_back(make_strobe(r.display_index, HUN1_HI, HUN1_LO, 1'b0, 1'b0));
            expected_strobes.push_back(make_strobe(r.display_index, HUN2_HI, HUN2_LO, 1'b0, 1'b0));
         end
         // pass 0: tens digit on map 0 (only above 9), pass 1: ones digit on map 1
         for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1 || lvl > 9) begin
               digit = (pass == 0) ? (lvl % 100) / 10 : lvl % 10;
               lit = DIGIT_LIT[7*digit +: 7];
               for (int seg = 0; seg < 7; seg++) begin
                  if (lit[seg])
                     expected_strobes.push_back(make_strobe(r.display_index,
                        (pass == 0) ? TENS_HI[3*seg +: 3] : ONES_HI[3*seg +: 3],
                        (pass == 0) ? TENS_LO[3*seg +: 3] : ONES_LO[3*seg +: 3],
                        1'b0, 1'b0));
               end
            end
         end
      end
      expected_strobes.push_back(make_strobe(r.display_index, 3'd0, 3'd0, 1'b1, 1'b1));
   endtask

   task automatic add_req(int idx, int lvl, int chg);
      req_type r;
      r.display_index = idx[1:0];
      r.level         = lvl[7:0];
      r.charging      = chg[0];
      pending_reqs.push_back(r);
   endtask

   // Request driver: holds each request until taken, random idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && sent_count != accept_count) begin
         req_valid <= 1'b1;
      end else if (req_gap_left > 0) begin
         req_gap_left = req_gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         req_gap_left = $urandom_range(1, 16) - 1;
         req_valid <= 1'b0;
      end else begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         sent_count = sent_count + 1;
      end
   end

   // Strobe receiver ready: random stall bursts plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_hold_done && accept_count >= HOLD_AFTER) begin
         rsp_hold_done = 1'b1;
         rsp_hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 16) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on each taken request, check each taken strobe.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_strobes_for(req_data);
            accept_count <= accept_count + 1;
            if (req_data.level == BLANK_CODE) blank_reqs <= blank_reqs + 1;
            else if (req_data.level >= 8'd100) hundred_reqs <= hundred_reqs + 1;
            if (req_data.charging) charge_reqs <= charge_reqs + 1;
         end
         if (rsp_valid && rsp_ready) begin
            strobe_count <= strobe_count + 1;
            if (expected_strobes.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= 10)
                  $display("ERROR: unexpected strobe mod=%0d hi=%0d lo=%0d off=%0b last=%0b",
                           rsp_data.module_out, rsp_data.drive_high, rsp_data.drive_low,
                           rsp_data.all_off, rsp_data.last);
            end else begin
               want = expected_strobes.pop_front();
               if (rsp_data.module_out !== want.module_out ||
                   rsp_data.drive_high !== want.drive_high ||
                   rsp_data.drive_low  !== want.drive_low  ||
                   rsp_data.all_off    !== want.all_off    ||
                   rsp_data.last       !== want.last) begin
                  error_count = error_count + 1;
                  if (error_count <= 10)
                     $display("ERROR: strobe %0d exp mod=%0d hi=%0d lo=%0d off=%0b last=%0b, got mod=%0d hi=%0d lo=%0d off=%0b last=%0b",
                              strobe_count, want.module_out, want.drive_high,
                              want.drive_low, want.all_off, want.last,
                              rsp_data.module_out, rsp_data.drive_high,
                              rsp_data.drive_low, rsp_data.all_off, rsp_data.last);
               end
            end
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int pick;
      int lvl;
      // directed: digit boundaries, hundreds range, blank, longest answer
      add_req(0, 0, 0);    add_req(1, 9, 1);    add_req(2, 10, 0);   add_req(3, 99, 1);
      add_req(0, 100, 0);  add_req(1, 101, 1);  add_req(2, 109, 0);  add_req(3, 110, 1);
      add_req(0, 199, 0);  add_req(1, 200, 1);  add_req(2, 254, 0);  add_req(3, 255, 0);
      add_req(0, 255, 1);  add_req(1, 188, 1);  add_req(2, 88, 0);   add_req(3, 8, 1);
      add_req(0, 1, 0);    add_req(1, 7, 0);    add_req(2, 47, 1);   add_req(3, 236, 1);
      add_req(0, 123, 0);  add_req(3, 65, 1);
      for (int n = 0; n < RANDOM_REQS; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       lvl = 255;
            1:       lvl = $urandom_range(0, 9);
            2, 3:    lvl = $urandom_range(10, 99);
            4:       lvl = $urandom_range(100, 109);
            5:       lvl = $urandom_range(200, 254);
            6:       lvl = $urandom_range(110, 199);
            default: lvl = $urandom_range(0, 255);
         endcase
         add_req($urandom_range(0, 3), lvl, $urandom_range(0, 1));
      end
      total_reqs = pending_reqs.size();

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (accept_count != total_reqs) @(posedge clock);
      while (expected_strobes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d blank, %0d with hundreds mark, %0d charging),",
               accept_count, blank_reqs, hundred_reqs, charge_reqs);
      $display("%0d strobes checked, %0d mismatches.", strobe_count, error_count);
      if (error_count == 0 && expected_strobes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/cpds_pkg.sv
rtl/core/cpds_digit_split.sv
rtl/core/charlieplex_percent_display_sequencer_unit.sv
tb/tb_charlieplex_percent_display_sequencer_unit.sv
